### rtl/nlim_pkg.sv
// Package for the number list index matcher: widths, character codes,
// register indexes and the structs passed between its modules.
// No dependencies.
`timescale 1ns / 1ps

package nlim_pkg;

    // Width of the tested index; numbers carry one bit more so that the
    // saturated value lies above every index that can be tested.
    localparam int INDEX_WIDTH = 16;
    localparam int NUM_W       = INDEX_WIDTH + 1;
    localparam int PROD_W      = NUM_W + 4;

    localparam logic [NUM_W-1:0] NUM_SAT = {NUM_W{1'b1}};

    // Pattern characters.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_LAYER_INDEX    = 2'd0,
        REG_LAYER_COUNT    = 2'd1,
        REG_COUNT_FROM_TOP = 2'd2,
        REG_INVERT_RESULT  = 2'd3
    } cfg_reg_t;

    // Index under test, as derived from the configuration registers.
    typedef struct packed {
        logic             ok;
        logic [NUM_W-1:0] value;
        logic             invert;
    } target_t;

    // End-of-pattern report from the parser.
    typedef struct packed {
        logic done;
        logic hit;
    } parse_result_t;

endpackage

### rtl/nlim_cfg.sv
// Configuration registers of the number list index matcher and the
// derivation of the index under test. Depends on nlim_pkg.
`timescale 1ns / 1ps

module nlim_cfg
    import nlim_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [1:0]       wr_index,
    input  logic [NUM_W-1:0] wr_data,
    output target_t          target
);

    logic [INDEX_WIDTH-1:0] layer_index_reg;
    logic [NUM_W-1:0]       layer_count_reg;
    logic                   count_from_top_reg;
    logic                   invert_result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_index_reg    <= '0;
            layer_count_reg    <= NUM_W'(1);
            count_from_top_reg <= 1'b0;
            invert_result_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_LAYER_INDEX:    layer_index_reg    <= wr_data[INDEX_WIDTH-1:0];
                REG_LAYER_COUNT:    layer_count_reg    <= wr_data;
                REG_COUNT_FROM_TOP: count_from_top_reg <= wr_data[0];
                REG_INVERT_RESULT:  invert_result_reg  <= wr_data[0];
                default:            ;
            endcase
        end
    end

    logic [NUM_W-1:0] index_ext;
    logic [NUM_W-1:0] top_value;

    assign index_ext = {1'b0, layer_index_reg};
    assign top_value = layer_count_reg - index_ext - NUM_W'(1);

    // Counting from the top is only valid when the count exceeds the index.
    always_comb
    begin
        target.invert = invert_result_reg;
        if (count_from_top_reg)
        begin
            target.ok    = (layer_count_reg > index_ext);
            target.value = top_value;
        end
        else
        begin
            target.ok    = 1'b1;
            target.value = index_ext;
        end
    end

endmodule

### rtl/nlim_parse.sv
// Parse state of the number list index matcher: digit accumulation,
// range tracking and the sticky match flag. Depends on nlim_pkg.
`timescale 1ns / 1ps

module nlim_parse
    import nlim_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    char_in,
    input  target_t       target,
    output parse_result_t result
);

    logic [NUM_W-1:0] acc_reg,   acc_next;
    logic             coll_reg,  coll_next;
    logic [NUM_W-1:0] last_reg,  last_next;
    logic             lnv_reg,   lnv_next;
    logic [NUM_W-1:0] start_reg, start_next;
    logic             open_reg,  open_next;
    logic             match_reg, match_next;

    logic [PROD_W-1:0] prod;
    logic              is_digit;

    assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    // Times ten as two shifts and an add, plus the digit value.
    assign prod = PROD_W'({acc_reg, 3'b000}) + PROD_W'({acc_reg, 1'b0})
                + PROD_W'(char_in - CH_ZERO);

    always_comb
    begin
        acc_next    = acc_reg;
        coll_next   = coll_reg;
        last_next   = last_reg;
        lnv_next    = lnv_reg;
        start_next  = start_reg;
        open_next   = open_reg;
        match_next  = match_reg;
        result.done = 1'b0;
        result.hit  = 1'b0;

        if (is_digit)
        begin
            acc_next  = (prod > PROD_W'(NUM_SAT)) ? NUM_SAT : prod[NUM_W-1:0];
            coll_next = 1'b1;
        end
        else
        begin
            // A non-digit completes a pending number first.
            if (coll_reg)
            begin
                if (target.ok)
                begin
                    if (acc_reg == target.value)
                        match_next = 1'b1;
                    if (open_reg && (target.value >= start_reg) && (target.value <= acc_reg))
                        match_next = 1'b1;
                end
                open_next = 1'b0;
                coll_next = 1'b0;
                acc_next  = '0;
                last_next = acc_reg;
                lnv_next  = 1'b1;
            end

            case (char_in)
                CH_NUL:
                begin
                    result.done = 1'b1;
                    result.hit  = match_next;
                    acc_next    = '0;
                    coll_next   = 1'b0;
                    last_next   = '0;
                    lnv_next    = 1'b0;
                    start_next  = '0;
                    open_next   = 1'b0;
                    match_next  = 1'b0;
                end
                CH_SPACE, CH_TAB: ;
                CH_COMMA:
                    lnv_next = 1'b0;
                CH_DASH:
                begin
                    if (lnv_next)
                    begin
                        start_next = last_next;
                        open_next  = 1'b1;
                    end
                end
                default:
                begin
                    lnv_next  = 1'b0;
                    open_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            coll_reg  <= 1'b0;
            last_reg  <= '0;
            lnv_reg   <= 1'b0;
            start_reg <= '0;
            open_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else if (step)
        begin
            acc_reg   <= acc_next;
            coll_reg  <= coll_next;
            last_reg  <= last_next;
            lnv_reg   <= lnv_next;
            start_reg <= start_next;
            open_reg  <= open_next;
            match_reg <= match_next;
        end
    end

endmodule

### rtl/number_list_index_matcher.sv
// Top level of the number list index matcher: input register, parser,
// configuration registers and result register. Depends on nlim_pkg,
// nlim_cfg and nlim_parse.
`timescale 1ns / 1ps

// The block reads a list pattern such as "0, 3-4, 7" one byte per beat and
// reports on the closing zero byte whether the configured index lies in the
// list; every other byte produces no result beat. Digits build a number that
// saturates above the index range, a dash after a number opens a range that
// the next number closes, a comma ends a number's ability to open a range,
// spaces and tabs are skipped, and any other byte ends that ability as well
// and closes any open range. With count_from_top set, the tested index is
// layer_count-1-layer_index, and nothing matches when that is negative.
// The block takes one byte every clock cycle while in_stall is low. A byte is
// captured in the input register and then applied to the parse state, and the
// result of a zero byte passes through the result register before it is
// offered. The single result register is the only point of back pressure:
// a zero byte waits in the input register while an earlier result is still
// stalled, and in_stall rises only then. Configuration writes take effect
// on the next cycle and are meant to be made between patterns.

module number_list_index_matcher
    import nlim_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [1:0]       wr_index,
    input  logic [NUM_W-1:0] wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       pattern_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             matched
);

    target_t       target;
    parse_result_t result;

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    logic       matched_reg;

    logic out_free;
    logic step;
    logic accept;

    // The result register can take a new beat if it is empty or draining.
    assign out_free = !out_valid_reg || !out_stall;
    // Only a zero byte produces a result, so only it waits on the output.
    assign step     = in_valid_reg && ((byte_reg != CH_NUL) || out_free);
    assign in_stall = in_valid_reg && !step;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            byte_reg <= pattern_byte;
    end

    nlim_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .target   (target)
    );

    nlim_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .char_in (byte_reg),
        .target  (target),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && result.done)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && result.done)
            matched_reg <= result.hit ^ target.invert;
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

endmodule

### sim/tb_number_list_index_matcher.sv
// Self-checking testbench for number_list_index_matcher: streams list patterns
// with random idling and back pressure and checks every result beat against a
// built-in parser model. Depends on nlim_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_number_list_index_matcher;
    import nlim_pkg::*;

    // Roughly how many random pattern bytes to send, and a cycle budget that is
    // far above the slowest legal run with the idling used here.
    localparam int RANDOM_BYTES = 1050;
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Cycles to let pass after the last expected beat before the block counts
    // as idle. A byte passes through the input register before the result register.
    localparam int SETTLE_CYCLES = 6;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             wr_en = 1'b0;
    logic [1:0]       wr_index = REG_LAYER_INDEX;
    logic [NUM_W-1:0] wr_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [7:0]       pattern_byte = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             matched;

    number_list_index_matcher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pattern_byte (pattern_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .matched      (matched)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Pattern bytes waiting for the driver, and match flags waiting for their
    // result beat, oldest first.
    logic [7:0] byte_q[$];
    logic       match_q[$];

    // Shadow copies of the configuration registers.
    logic [INDEX_WIDTH-1:0] cfg_layer_index = '0;
    logic [NUM_W-1:0]       cfg_layer_count = NUM_W'(1);
    logic                   cfg_from_top = 1'b0;
    logic                   cfg_invert = 1'b0;

    // Parser state of the model, all clear after reset.
    logic [NUM_W-1:0] num_acc = '0;
    logic             in_number = 1'b0;
    logic [NUM_W-1:0] prev_num = '0;
    logic             prev_num_ok = 1'b0;
    logic [NUM_W-1:0] span_lo = '0;
    logic             span_open = 1'b0;
    logic             index_hit = 1'b0;

    int          fail_count = 0;
    int          results_checked = 0;
    int          patterns_sent = 0;
    int          bytes_queued = 0;
    int          reg_writes = 0;
    int          backpressure_cycles = 0;
    int unsigned cycle_count = 0;

    // Index that a completed number is compared with. When counting from the
    // top and the difference goes negative, no number can match.
    function automatic void tested_index(output logic ok, output logic [NUM_W-1:0] t);
        ok = 1'b1;
        t  = {1'b0, cfg_layer_index};
        if (cfg_from_top)
        begin
            if (cfg_layer_count < {1'b0, cfg_layer_index} + 1)
                ok = 1'b0;
            else
                t = cfg_layer_count - NUM_W'(1) - {1'b0, cfg_layer_index};
        end
    endfunction

    // Applies one accepted byte to the model and queues the flag of a zero byte.
    function automatic void parse_list_byte(logic [7:0] b);
        logic             ok;
        logic [NUM_W-1:0] t;
        logic [NUM_W+3:0] grown;
        if (b >= CH_ZERO && b <= CH_NINE)
        begin
            grown     = PROD_W'(num_acc * 10 + (b - CH_ZERO));
            num_acc   = (grown > NUM_SAT) ? NUM_SAT : grown[NUM_W-1:0];
            in_number = 1'b1;
            return;
        end
        // Any other byte completes a number in progress.
        if (in_number)
        begin
            tested_index(ok, t);
            if (ok && num_acc == t)
                index_hit = 1'b1;
            if (ok && span_open && t >= span_lo && t <= num_acc)
                index_hit = 1'b1;
            span_open   = 1'b0;
            in_number   = 1'b0;
            prev_num    = num_acc;
            prev_num_ok = 1'b1;
            num_acc     = '0;
        end
        case (b)
            CH_NUL:
            begin
                match_q.push_back(index_hit ^ cfg_invert);
                num_acc     = '0;
                in_number   = 1'b0;
                prev_num    = '0;
                prev_num_ok = 1'b0;
                span_lo     = '0;
                span_open   = 1'b0;
                index_hit   = 1'b0;
            end
            CH_SPACE, CH_TAB: ;
            CH_COMMA: prev_num_ok = 1'b0;
            CH_DASH:
            begin
                // A dash only opens a range right after a number.
                if (prev_num_ok)
                begin
                    span_lo   = prev_num;
                    span_open = 1'b1;
                end
            end
            default:
            begin
                prev_num_ok = 1'b0;
                span_open   = 1'b0;
            end
        endcase
    endfunction

    // Input side: bursts of random length separated by random gaps. A beat
    // stays on the port unchanged until the block takes it.
    logic byte_taken = 1'b0;
    int   burst_left = 1;
    int   gap_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !byte_taken)
        begin
            // Still waiting for the block to take the current beat.
        end
        else if (gap_left != 0)
        begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (byte_q.size() != 0)
        begin
            pattern_byte <= byte_q.pop_front();
            in_valid     <= 1'b1;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 24);
                // A third of the bursts run straight into the next one.
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
            else
            begin
                burst_left <= burst_left - 1;
            end
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Result side: the stall pattern steps with rx_cycle through no stalls,
    // light and heavy random stalls and strict alternation. Once in each longer
    // period of rx_cycle it holds off for a long stretch so that a result waits in
    // the output register, the next zero byte waits behind it and the input
    // stalls while the sender keeps offering beats.
    int rx_cycle = 0;
    int hold_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (rx_cycle % 1500 == 400)
            begin
                out_stall <= 1'b1;
                hold_left <= 60;
            end
            else
            begin
                case ((rx_cycle / 128) % 4)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= rx_cycle[0];
                endcase
            end
        end
    end

    // Monitor: checks result beats against the oldest waiting flag, feeds
    // accepted input beats to the model and enforces the cycle budget.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, match_q.size());
            $display("[number_list_index_matcher] ERROR");
            $finish;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (!rst_n)
            begin
                byte_taken <= 1'b0;
            end
            else
            begin
                byte_taken <= in_valid && !in_stall;
                if (in_valid && in_stall)
                    backpressure_cycles <= backpressure_cycles + 1;
                if (out_valid && !out_stall)
                begin
                    if (match_q.size() == 0)
                    begin
                        $error("result beat with no pattern end waiting, matched=%0b", matched);
                        fail_count <= fail_count + 1;
                    end
                    else
                    begin
                        if (matched !== match_q[0])
                        begin
                            $error("matched: expected %0b, got %0b", match_q[0], matched);
                            fail_count <= fail_count + 1;
                        end
                        void'(match_q.pop_front());
                        results_checked <= results_checked + 1;
                    end
                end
                if (in_valid && !in_stall)
                    parse_list_byte(pattern_byte);
            end
        end
    end

    function automatic void put(logic [7:0] b);
        byte_q.push_back(b);
        bytes_queued++;
    endfunction

    function automatic void put_text(string s);
        foreach (s[k])
            put(s[k]);
    endfunction

    function automatic void put_pattern(string s);
        put_text(s);
        put(CH_NUL);
        patterns_sent++;
    endfunction

    // Decimal text of a number, now and then with a leading zero.
    function automatic void put_number(int n);
        if ($urandom_range(0, 7) == 0)
            put(CH_ZERO);
        put_text($sformatf("%0d", n));
    endfunction

    // Numbers cluster around the tested index so that hits, near misses and
    // range edges come up often; some are far beyond the index range.
    function automatic int pick_number(logic ok, logic [NUM_W-1:0] t);
        int n;
        case ($urandom_range(0, 5))
            0, 1: n = ok ? int'(t) : $urandom_range(0, 20);
            2: n = ok ? int'(t) + int'($urandom_range(0, 2)) - 1 : 0;
            3: n = $urandom_range(0, 20);
            4: n = $urandom_range(0, 65535);
            default: n = $urandom_range(65536, 9999999);
        endcase
        return (n < 0) ? 0 : n;
    endfunction

    function automatic void put_blanks();
        repeat ($urandom_range(0, 2))
            put(($urandom_range(0, 2) == 0) ? CH_TAB : CH_SPACE);
    endfunction

    // Mostly well-formed lists with random content; the rest are plain noise
    // or lists with stray characters in them.
    function automatic void put_random_pattern();
        logic             ok;
        logic [NUM_W-1:0] t;
        int               lo_n;
        tested_index(ok, t);
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 10))
                put(8'($urandom_range(1, 255)));
        end
        else
        begin
            for (int e = $urandom_range(1, 5); e > 0; e--)
            begin
                put_blanks();
                lo_n = pick_number(ok, t);
                put_number(lo_n);
                if ($urandom_range(0, 2) == 0)
                begin
                    put_blanks();
                    put(CH_DASH);
                    put_blanks();
                    if ($urandom_range(0, 1) == 0)
                        put_number(lo_n + $urandom_range(0, 5));
                    else
                        put_number(pick_number(ok, t));
                end
                if ($urandom_range(0, 11) == 0)
                    put(8'($urandom_range(1, 255)));
                put_blanks();
                if (e > 1 && $urandom_range(0, 7) != 0)
                    put(CH_COMMA);
            end
        end
        put(CH_NUL);
        patterns_sent++;
    endfunction

    // One register write; the shadow copy follows with the register's width.
    task automatic write_reg(cfg_reg_t r, logic [NUM_W-1:0] v);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= r;
        wr_data  <= v;
        case (r)
            REG_LAYER_INDEX:    cfg_layer_index = v[INDEX_WIDTH-1:0];
            REG_LAYER_COUNT:    cfg_layer_count = v;
            REG_COUNT_FROM_TOP: cfg_from_top = v[0];
            default:            cfg_invert = v[0];
        endcase
        reg_writes++;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // Returns once every queued byte has gone in, every result has come out
    // and the pipeline has had time to absorb trailing non-zero bytes.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (byte_q.size() != 0 || in_valid || match_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic randomize_config();
        int idx;
        int cnt;
        case ($urandom_range(0, 3))
            0: idx = 0;
            1: idx = 65535;
            2: idx = $urandom_range(0, 20);
            default: idx = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 3))
            0: cnt = 1;
            1: cnt = 65536;
            2: cnt = idx + $urandom_range(0, 3);
            default: cnt = $urandom_range(1, 65536);
        endcase
        if (cnt < 1)
            cnt = 1;
        if (cnt > 65536)
            cnt = 65536;
        // Bits above a register's width are random and must be dropped.
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_LAYER_INDEX, {1'($urandom_range(0, 1)), 16'(idx)});
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_LAYER_COUNT, NUM_W'(cnt));
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_COUNT_FROM_TOP, NUM_W'($urandom_range(0, 131071)));
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_INVERT_RESULT, NUM_W'($urandom_range(0, 131071)));
    endtask

    initial
    begin
        int phase_end;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, starting from the reset configuration (index 0).
        // A lone zero, then blanks, a range that misses, a dash with no
        // number before it and a stray character.
        put_pattern("0");
        put_pattern("\t1 -  2,x-0");
        wait_drained();

        // Widest index and count, inverted flag; numbers far past the index
        // range saturate, and a stray character cancels an open range.
        write_reg(REG_LAYER_INDEX, NUM_SAT);
        write_reg(REG_LAYER_COUNT, NUM_W'(65536));
        write_reg(REG_INVERT_RESULT, NUM_W'(1));
        put_pattern("99999999,65535");
        put_pattern("65534-#65536");
        wait_drained();

        // Counting from the top gives index 0 here; bytes after the hit are
        // still parsed but cannot clear it.
        write_reg(REG_COUNT_FROM_TOP, NUM_W'(1));
        put_pattern("0x");
        wait_drained();

        // Smallest count with a larger index: the tested index is negative.
        write_reg(REG_LAYER_COUNT, NUM_W'(1));
        write_reg(REG_LAYER_INDEX, NUM_W'(5));
        put_pattern("0-99999");
        wait_drained();

        // Registers change while a number is still open; the number is
        // compared with the new setting when the comma completes it.
        put_text("4");
        wait_drained();
        write_reg(REG_COUNT_FROM_TOP, NUM_W'(0));
        write_reg(REG_LAYER_INDEX, NUM_W'(4));
        write_reg(REG_INVERT_RESULT, NUM_W'(0));
        put_pattern(",7");
        wait_drained();

        // Random part in phases, each under a fresh configuration.
        bytes_queued = 0;
        while (bytes_queued < RANDOM_BYTES)
        begin
            randomize_config();
            phase_end = bytes_queued + $urandom_range(60, 200);
            while (bytes_queued < phase_end && bytes_queued < RANDOM_BYTES)
                put_random_pattern();
            wait_drained();
        end

        $display("Sent %0d patterns with %0d register writes; %0d results checked.",
                 patterns_sent, reg_writes, results_checked);
        $display("The input was held off by back pressure in %0d cycles.",
                 backpressure_cycles);
        if (fail_count == 0)
            $display("[number_list_index_matcher] OK");
        else
            $display("[number_list_index_matcher] ERROR");
        $finish;
    end

endmodule
